[design/bht_pkg.sv]
// Package for the bucketed hash table: sizes, operation and status codes,
// and the row and decision types shared by the table's modules.
// No dependencies.
`default_nettype none

package bht_pkg;

  // The bucket count is a power of two, so the bucket is the low key bits.
  localparam int unsigned NUM_BUCKETS     = 16;
  localparam int unsigned WAYS_PER_BUCKET = 4;
  localparam int unsigned SLOT_TOTAL      = NUM_BUCKETS * WAYS_PER_BUCKET;

  localparam int unsigned KEY_W    = 31;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned BUCKET_W = $clog2(NUM_BUCKETS);
  localparam int unsigned WAY_W    = (WAYS_PER_BUCKET > 1) ? $clog2(WAYS_PER_BUCKET) : 1;
  localparam int unsigned COUNT_W  = $clog2(SLOT_TOTAL + 1);

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_REPLACED  = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_REMOVED   = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_FOUND     = 3'd4;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd5;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } entry_t;

  typedef entry_t [WAYS_PER_BUCKET-1:0] row_t;
  typedef logic [WAYS_PER_BUCKET-1:0]   valid_row_t;

  localparam int unsigned ROW_W = $bits(row_t);

  // What one operation does to its bucket and what it answers.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  found_value;
    logic                write_row;
    logic                set_valid;
    logic                clr_valid;
    logic [WAY_W-1:0]    way;
  } decision_t;

endpackage

`default_nettype wire

[design/bht_in_if.sv]
// Request channel of the bucketed hash table: valid, ready and one request.
// Depends on bht_pkg.
`default_nettype none

interface bht_in_if;
  import bht_pkg::*;

  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [KEY_W-1:0]    item_key;
  logic [VALUE_W-1:0]  item_value;

  modport source (output valid, operation, item_key, item_value, input ready);
  modport sink   (input valid, operation, item_key, item_value, output ready);
endinterface

`default_nettype wire

[design/bht_out_if.sv]
// Result channel of the bucketed hash table: valid, ready and one result.
// Depends on bht_pkg.
`default_nettype none

interface bht_out_if;
  import bht_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [VALUE_W-1:0]  found_value;
  logic                table_empty;

  modport source (output valid, status, found_value, table_empty, input ready);
  modport sink   (input valid, status, found_value, table_empty, output ready);
endinterface

`default_nettype wire

[design/bht_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module bht_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // Read data holds while no read is issued.
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[design/bht_bucket_eval.sv]
// Compares all ways of one bucket row against the key and decides the
// outcome of the operation, along with the row to write back.
// Depends on bht_pkg.
`default_nettype none

module bht_bucket_eval (
  input  wire logic [bht_pkg::OP_W-1:0]    operation_i,
  input  wire logic [bht_pkg::KEY_W-1:0]   item_key_i,
  input  wire logic [bht_pkg::VALUE_W-1:0] item_value_i,
  input  wire bht_pkg::row_t               row_i,
  input  wire bht_pkg::valid_row_t         valid_i,
  output      bht_pkg::decision_t          decision_o,
  output      bht_pkg::row_t               row_o
);
  import bht_pkg::*;

  logic             any_hit;
  logic             any_free;
  logic [WAY_W-1:0] hit_way;
  logic [WAY_W-1:0] free_way;

  // Lowest-numbered matching way and lowest-numbered free way.
  always_comb begin
    any_hit  = 1'b0;
    any_free = 1'b0;
    hit_way  = '0;
    free_way = '0;
    for (int w = WAYS_PER_BUCKET - 1; w >= 0; w--) begin
      if (valid_i[w] && (row_i[w].key == item_key_i)) begin
        any_hit = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (!valid_i[w]) begin
        any_free = 1'b1;
        free_way = WAY_W'(w);
      end
    end
  end

  always_comb begin
    decision_o             = '0;
    decision_o.status      = STAT_NOT_FOUND;
    decision_o.found_value = '0;
    row_o                  = row_i;
    unique case (operation_i)
      OP_INSERT: begin
        if (any_hit) begin
          row_o[hit_way].value  = item_value_i;
          decision_o.write_row  = 1'b1;
          decision_o.way        = hit_way;
          decision_o.status     = STAT_REPLACED;
        end else if (any_free) begin
          row_o[free_way].key   = item_key_i;
          row_o[free_way].value = item_value_i;
          decision_o.write_row  = 1'b1;
          decision_o.set_valid  = 1'b1;
          decision_o.way        = free_way;
          decision_o.status     = STAT_INSERTED;
        end else begin
          decision_o.status     = STAT_FULL;
        end
      end
      OP_REMOVE: begin
        if (any_hit) begin
          decision_o.clr_valid = 1'b1;
          decision_o.way       = hit_way;
          decision_o.status    = STAT_REMOVED;
        end
      end
      OP_LOOKUP: begin
        if (any_hit) begin
          decision_o.found_value = row_i[hit_way].value;
          decision_o.status      = STAT_FOUND;
        end
      end
      default: begin
        // The unused operation code changes nothing and reports not found.
      end
    endcase
  end

endmodule

`default_nettype wire

[design/bucketed_hash_table_unit.sv]
// Bucketed key-value table: one bucket row per RAM word, ways compared in
// parallel. Depends on bht_pkg, bht_in_if, bht_out_if, bht_ram, bht_bucket_eval.
//
// Usage:
//   in_i carries requests (operation, item_key, item_value); out_o carries
//   one result per request (status, found_value, table_empty), in order.
//   The bucket is the low bits of the key; each bucket has a fixed number
//   of ways, and an insert into a full bucket reports bucket full.
//   The beat is accepted while the bucket row is read from the RAM, and in
//   the EVAL state the ways are compared; once the result may be loaded,
//   the row is written back and the result is loaded into the output register.
//   A new request is accepted only in IDLE, so the unit takes no new request
//   before the last one has been evaluated. Each result is held in the output
//   register until out_o takes it.
//   The output register lets the next request be accepted while a result
//   waits; if the receiver still stalls when that request is evaluated, the
//   unit holds it and accepts nothing further until the result is taken.
//   Reset clears all valid bits and the entry count at once; no clearing
//   pass is needed, and requests are accepted right after reset.
`default_nettype none

module bucketed_hash_table_unit (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  bht_in_if.sink    in_i,
  bht_out_if.source out_o
);
  import bht_pkg::*;

  typedef enum logic {
    IDLE,
    EVAL
  } state_e;

  state_e              state_q;
  valid_row_t          valid_q [NUM_BUCKETS];
  logic [COUNT_W-1:0]  count_q;
  logic [COUNT_W-1:0]  count_d;
  logic                out_valid_q;
  logic [STATUS_W-1:0] status_q;
  logic [VALUE_W-1:0]  found_q;
  logic                empty_q;

  logic [OP_W-1:0]     op_q;
  logic [KEY_W-1:0]    key_q;
  logic [VALUE_W-1:0]  value_q;

  logic                accept;
  logic                commit;
  logic [BUCKET_W-1:0] eval_bucket;
  logic [ROW_W-1:0]    ram_rdata;
  row_t                row_rd;
  row_t                row_wr;
  decision_t           dec;

  assign in_i.ready  = (state_q == IDLE);
  assign accept      = in_i.valid && in_i.ready;
  assign eval_bucket = key_q[BUCKET_W-1:0];
  assign row_rd      = ram_rdata;

  // A result may be produced when the output register is free or drains now.
  assign commit = (state_q == EVAL) && (!out_valid_q || out_o.ready);

  bht_ram #(
    .Width (ROW_W),
    .Depth (NUM_BUCKETS)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (commit && dec.write_row),
    .waddr_i (eval_bucket),
    .wdata_i (row_wr),
    .re_i    (accept),
    .raddr_i (in_i.item_key[BUCKET_W-1:0]),
    .rdata_o (ram_rdata)
  );

  bht_bucket_eval u_eval (
    .operation_i  (op_q),
    .item_key_i   (key_q),
    .item_value_i (value_q),
    .row_i        (row_rd),
    .valid_i      (valid_q[eval_bucket]),
    .decision_o   (dec),
    .row_o        (row_wr)
  );

  assign count_d = count_q + COUNT_W'(dec.set_valid) - COUNT_W'(dec.clr_valid);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= in_i.operation;
      key_q   <= in_i.item_key;
      value_q <= in_i.item_value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      status_q    <= '0;
      found_q     <= '0;
      empty_q     <= 1'b1;
      for (int b = 0; b < NUM_BUCKETS; b++) begin
        valid_q[b] <= '0;
      end
    end else begin
      unique case (state_q)
        IDLE: begin
          if (accept) begin
            state_q <= EVAL;
          end
          if (out_o.ready) begin
            out_valid_q <= 1'b0;
          end
        end
        EVAL: begin
          if (commit) begin
            state_q     <= IDLE;
            out_valid_q <= 1'b1;
            status_q    <= dec.status;
            found_q     <= dec.found_value;
            empty_q     <= (count_d == '0);
            count_q     <= count_d;
            if (dec.set_valid) begin
              valid_q[eval_bucket][dec.way] <= 1'b1;
            end
            if (dec.clr_valid) begin
              valid_q[eval_bucket][dec.way] <= 1'b0;
            end
          end
        end
        default: begin
          state_q <= IDLE;
        end
      endcase
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = status_q;
  assign out_o.found_value = found_q;
  assign out_o.table_empty = empty_q;

endmodule

`default_nettype wire
